// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the failed attempt limiter RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a generic message, disabled while reset is held.
`define ASSERT_SYNC(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion with a caller-supplied message string.
`define ASSERT_SYNC_MSG(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

// ===== rtl/fal_pkg.sv =====
// Types and constants of the failed attempt limiter.
// Depends on nothing; used by the table, the time unit and the top level.
package fal_pkg;

  localparam int KEY_W  = 64;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 8;
  localparam int SECS_W = 24;
  localparam int CFG_W  = 24;

  localparam logic [1:0] OP_FAIL   = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_FORGET = 2'd2;

  localparam logic [1:0] CFG_MAX_FAILS = 2'd0;
  localparam logic [1:0] CFG_WINDOW    = 2'd1;
  localparam logic [1:0] CFG_BLOCK     = 2'd2;

  localparam logic [CNT_W-1:0]  MAX_FAILS_RST = 8'd5;
  localparam logic [CFG_W-1:0]  WINDOW_RST    = 24'd300;
  localparam logic [CFG_W-1:0]  BLOCK_RST     = 24'd900;
  localparam logic [SECS_W-1:0] SECONDS_MAX   = 24'hFFFFFF;
  localparam logic [CNT_W-1:0]  COUNT_MAX     = 8'hFF;

  // One client record as held in the table memory.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] win_start;
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] blk_until;
  } rec_t;

  // Time checks on one record against the current time.
  typedef struct packed {
    logic              win_over;   // window has run out
    logic              left_pos;   // block end lies in the future
    logic              stale;      // neither blocked nor counting
    logic [SECS_W-1:0] secs_left;  // saturated seconds to block end
    logic [TIME_W-1:0] block_end;  // time_now + block_seconds, wrapped
  } tchk_t;

endpackage

// ===== rtl/fal_table.sv =====
// Client record table: a record memory and a valid-bit memory, each with
// one write port and one registered read port. Depends on fal_pkg.
module fal_table #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic                clk,
  input  logic [IDX_W-1:0]    rd_addr,
  output fal_pkg::rec_t       rd_rec,
  output logic                rd_valid,
  input  logic                rec_we,
  input  logic                vld_we,
  input  logic [IDX_W-1:0]    wr_addr,
  input  fal_pkg::rec_t       wr_rec,
  input  logic                wr_valid
);

  fal_pkg::rec_t rec_mem [DEPTH];
  logic          vld_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[wr_addr] <= wr_rec;
    end
    rd_rec <= rec_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[wr_addr] <= wr_valid;
    end
    rd_valid <= vld_mem[rd_addr];
  end

endmodule

// ===== rtl/fal_time_unit.sv =====
// Shared time unit: window expiry, block end and seconds left of one record.
// Depends on fal_pkg; used by the sequencer for scan results and the sweep.
module fal_time_unit (
  input  logic [fal_pkg::TIME_W-1:0] now,
  input  fal_pkg::rec_t              rec,
  input  logic [fal_pkg::CFG_W-1:0]  window_seconds,
  input  logic [fal_pkg::CFG_W-1:0]  block_seconds,
  output fal_pkg::tchk_t             chk
);

  logic [fal_pkg::TIME_W:0] since_start;
  logic [fal_pkg::TIME_W:0] to_end;
  logic                     blocked;
  logic                     counting;

  // Both differences are exact 33-bit signed values, so time running
  // backwards gives a negative result instead of a wrap.
  assign since_start = {1'b0, now} - {1'b0, rec.win_start};
  assign to_end      = {1'b0, rec.blk_until} - {1'b0, now};

  always_comb begin
    chk.win_over  = !since_start[fal_pkg::TIME_W] &&
                    (since_start[fal_pkg::TIME_W-1:0] >=
                     {{(fal_pkg::TIME_W-fal_pkg::CFG_W){1'b0}}, window_seconds});
    chk.left_pos  = !to_end[fal_pkg::TIME_W] &&
                    (to_end[fal_pkg::TIME_W-1:0] != '0);
    if (to_end[fal_pkg::TIME_W-1:fal_pkg::SECS_W] != '0) begin
      chk.secs_left = fal_pkg::SECONDS_MAX;
    end else begin
      chk.secs_left = to_end[fal_pkg::SECS_W-1:0];
    end
    chk.block_end = now + {{(fal_pkg::TIME_W-fal_pkg::CFG_W){1'b0}}, block_seconds};
    blocked       = (rec.blk_until != '0) && chk.left_pos;
    counting      = (rec.blk_until == '0) && !chk.win_over;
    chk.stale     = !blocked && !counting;
  end

endmodule

// ===== rtl/failed_attempt_limiter_unit.sv =====
// Failed attempt limiter, top level. Each word takes one pass over the
// table, one entry a cycle through the single read port of the record
// memory. A failure from a new client that finds the table full adds a
// sweep pass over the table. After reset a clearing pass over every entry
// resets the valid bits; no word is taken until it ends, while
// configuration writes are taken at any time. A new word is taken as soon
// as the previous one has moved into the output register.
`include "assert_macros.svh"

module failed_attempt_limiter_unit #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_opcode,
  input  logic [fal_pkg::KEY_W-1:0]   in_client_key,
  input  logic                        in_key_present,
  input  logic [fal_pkg::TIME_W-1:0]  in_time_now,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fal_pkg::SECS_W-1:0]  out_blocked_seconds,
  output logic                        out_dropped,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [fal_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_SWEEP  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic [IDX_W-1:0]            addr_r, addr_nxt;
  logic                        issue_r, issue_nxt;
  logic                        pend_r, pend_nxt;
  logic [IDX_W-1:0]            ridx_r, ridx_nxt;
  logic                        found_r, found_nxt;
  logic [IDX_W-1:0]            hit_idx_r, hit_idx_nxt;
  fal_pkg::rec_t               hit_rec_r, hit_rec_nxt;
  logic                        free_found_r, free_found_nxt;
  logic [IDX_W-1:0]            free_idx_r, free_idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [fal_pkg::SECS_W-1:0]  out_secs_r;
  logic                        out_drop_r;
  logic [1:0]                  op_r;
  logic [fal_pkg::KEY_W-1:0]   key_r;
  logic                        present_r;
  logic [fal_pkg::TIME_W-1:0]  now_r;
  logic [fal_pkg::CNT_W-1:0]   max_fails_r;
  logic [fal_pkg::CFG_W-1:0]   window_r;
  logic [fal_pkg::CFG_W-1:0]   block_r;

  logic                        accept;
  logic                        out_free;
  logic                        out_load;
  logic [fal_pkg::SECS_W-1:0]  res_secs;
  logic                        res_drop;

  fal_pkg::rec_t               rd_rec;
  logic                        rd_valid;
  logic                        rec_we;
  logic                        vld_we;
  logic [IDX_W-1:0]            wr_addr;
  fal_pkg::rec_t               wr_rec;
  logic                        wr_valid;

  fal_pkg::rec_t               tu_rec;
  fal_pkg::tchk_t              chk;

  logic                        restart;
  logic [fal_pkg::CNT_W-1:0]   base_cnt;
  logic [fal_pkg::CNT_W-1:0]   inc_cnt;
  logic                        now_blocks;
  fal_pkg::rec_t               upd_rec;
  logic [fal_pkg::SECS_W-1:0]  upd_secs;
  logic                        entry_free;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_blocked_seconds = out_secs_r;
  assign out_dropped = out_drop_r;

  fal_table #(
    .DEPTH (TABLE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .rd_addr  (addr_r),
    .rd_rec   (rd_rec),
    .rd_valid (rd_valid),
    .rec_we   (rec_we),
    .vld_we   (vld_we),
    .wr_addr  (wr_addr),
    .wr_rec   (wr_rec),
    .wr_valid (wr_valid)
  );

  // The sweep checks each record as it comes out of memory; every other
  // use checks the record captured during the scan.
  assign tu_rec = (state_r == ST_SWEEP) ? rd_rec : hit_rec_r;

  fal_time_unit u_time (
    .now            (now_r),
    .rec            (tu_rec),
    .window_seconds (window_r),
    .block_seconds  (block_r),
    .chk            (chk)
  );

  // Failure update. A new record, a blocked one or one whose window ran out
  // starts over from a zero count.
  always_comb begin
    restart    = (state_r == ST_FINISH) || !found_r ||
                 (hit_rec_r.blk_until != '0) || chk.win_over;
    base_cnt   = restart ? '0 : hit_rec_r.cnt;
    inc_cnt    = (base_cnt == fal_pkg::COUNT_MAX) ? fal_pkg::COUNT_MAX
                                                  : base_cnt + 8'd1;
    now_blocks = (inc_cnt >= max_fails_r);
    upd_rec.key       = key_r;
    upd_rec.win_start = restart ? now_r : hit_rec_r.win_start;
    upd_rec.cnt       = now_blocks ? '0 : inc_cnt;
    upd_rec.blk_until = now_blocks ? chk.block_end : '0;
    upd_secs          = now_blocks ? block_r : '0;
  end

  assign entry_free = !rd_valid || chk.stale;

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    ridx_nxt       = ridx_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_rec_nxt    = hit_rec_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_load       = 1'b0;
    res_secs       = '0;
    res_drop       = 1'b0;
    rec_we         = 1'b0;
    vld_we         = 1'b0;
    wr_addr        = ridx_r;
    wr_rec         = upd_rec;
    wr_valid       = 1'b0;

    // Read issue for the scan and the sweep: the data returns in the cycle after the issue.
    if ((state_r == ST_SCAN) || (state_r == ST_SWEEP)) begin
      if (issue_r) begin
        pend_nxt = 1'b1;
        ridx_nxt = addr_r;
        if (addr_r == LAST_IDX) begin
          issue_nxt = 1'b0;
        end else begin
          addr_nxt = addr_r + IDX_W'(1);
        end
      end
    end

    case (state_r)
      ST_CLEAR: begin
        vld_we   = 1'b1;
        wr_addr  = addr_r;
        wr_valid = 1'b0;
        if (addr_r == LAST_IDX) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt      = ST_SCAN;
          addr_nxt       = '0;
          issue_nxt      = 1'b1;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (pend_r) begin
          if (rd_valid && (rd_rec.key == key_r) && !found_r) begin
            found_nxt   = 1'b1;
            hit_idx_nxt = ridx_r;
            hit_rec_nxt = rd_rec;
          end
          if (!rd_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = ridx_r;
          end
          if (ridx_r == LAST_IDX) begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (present_r && (op_r == fal_pkg::OP_FAIL) && !found_r && !free_found_r) begin
          state_nxt = ST_SWEEP;
          addr_nxt  = '0;
          issue_nxt = 1'b1;
        end else if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_load      = 1'b1;
          if (present_r) begin
            case (op_r)
              fal_pkg::OP_FAIL: begin
                rec_we   = 1'b1;
                vld_we   = 1'b1;
                wr_valid = 1'b1;
                wr_addr  = found_r ? hit_idx_r : free_idx_r;
                res_secs = upd_secs;
              end
              fal_pkg::OP_QUERY: begin
                if (found_r && (hit_rec_r.blk_until != '0)) begin
                  if (chk.left_pos) begin
                    res_secs = chk.secs_left;
                  end else begin
                    vld_we  = 1'b1;
                    wr_addr = hit_idx_r;
                  end
                end
              end
              fal_pkg::OP_FORGET: begin
                if (found_r) begin
                  vld_we  = 1'b1;
                  wr_addr = hit_idx_r;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_SWEEP: begin
        if (pend_r) begin
          if (rd_valid && chk.stale) begin
            vld_we  = 1'b1;
            wr_addr = ridx_r;
          end
          if (entry_free && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = ridx_r;
          end
          if (ridx_r == LAST_IDX) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_load      = 1'b1;
          if (free_found_r) begin
            rec_we   = 1'b1;
            vld_we   = 1'b1;
            wr_valid = 1'b1;
            wr_addr  = free_idx_r;
            res_secs = upd_secs;
          end else begin
            res_drop = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      addr_r       <= '0;
      issue_r      <= 1'b0;
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      issue_r      <= issue_nxt;
      pend_r       <= pend_nxt;
      found_r      <= found_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r     <= ridx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_rec_r  <= hit_rec_nxt;
    free_idx_r <= free_idx_nxt;
    if (accept) begin
      op_r      <= in_opcode;
      key_r     <= in_client_key;
      present_r <= in_key_present;
      now_r     <= in_time_now;
    end
    if (out_load) begin
      out_secs_r <= res_secs;
      out_drop_r <= res_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fails_r <= fal_pkg::MAX_FAILS_RST;
      window_r    <= fal_pkg::WINDOW_RST;
      block_r     <= fal_pkg::BLOCK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fal_pkg::CFG_MAX_FAILS: max_fails_r <= cfg_wdata[fal_pkg::CNT_W-1:0];
        fal_pkg::CFG_WINDOW:    window_r    <= cfg_wdata;
        fal_pkg::CFG_BLOCK:     block_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  `ASSERT_SYNC_MSG(a_out_from_finish, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == ST_DECIDE || $past(state_r) == ST_FINISH), "result word appeared outside a finishing state")
  `ASSERT_SYNC_MSG(a_accept_starts_scan, clk, rst_n, (in_valid && !in_stall) |=> (state_r == ST_SCAN && addr_r == '0 && issue_r), "accepted word did not start a scan from entry zero")
  `ASSERT_SYNC_MSG(a_pend_in_pass, clk, rst_n, pend_r |-> (state_r == ST_SCAN || state_r == ST_SWEEP), "table read returned outside a scan or sweep")
  `ASSERT_SYNC(a_drop_no_secs, clk, rst_n, (out_valid_r && out_drop_r) |-> (out_secs_r == '0))

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the failed attempt limiter: directed and random words with
// a predictor of the client table kept in step. Depends on fal_pkg and on
// failed_attempt_limiter_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 2 * DEPTH + 16;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [fal_pkg::SECS_W-1:0] secs;
    logic                       dropped;
  } reply_t;

  typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PULSE} stall_mode_t;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_opcode      = fal_pkg::OP_FAIL;
  logic [fal_pkg::KEY_W-1:0]  in_client_key  = '0;
  logic                       in_key_present = 1'b0;
  logic [fal_pkg::TIME_W-1:0] in_time_now    = '0;
  logic                       out_valid;
  logic                       out_stall      = 1'b0;
  logic [fal_pkg::SECS_W-1:0] out_blocked_seconds;
  logic                       out_dropped;
  logic                       cfg_we         = 1'b0;
  logic [1:0]                 cfg_index      = fal_pkg::CFG_MAX_FAILS;
  logic [fal_pkg::CFG_W-1:0]  cfg_wdata      = '0;

  // Predicted limits and client table.
  logic [fal_pkg::CNT_W-1:0]  lim_max_fails = fal_pkg::MAX_FAILS_RST;
  logic [fal_pkg::CFG_W-1:0]  lim_window    = fal_pkg::WINDOW_RST;
  logic [fal_pkg::CFG_W-1:0]  lim_block     = fal_pkg::BLOCK_RST;
  logic                       rec_valid [DEPTH];
  logic [fal_pkg::KEY_W-1:0]  rec_key   [DEPTH];
  logic [fal_pkg::TIME_W-1:0] rec_start [DEPTH];
  logic [fal_pkg::CNT_W-1:0]  rec_count [DEPTH];
  logic [fal_pkg::TIME_W-1:0] rec_until [DEPTH];

  reply_t      replies_due[$];
  reply_t      reply_head;
  int          errors       = 0;
  int          results_seen = 0;
  int          cycles       = 0;
  int          burst_left   = 0;
  int          stall_run    = 0;
  stall_mode_t stall_mode   = STALL_NONE;

  failed_attempt_limiter_unit #(
    .TABLE_ENTRIES(DEPTH)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_client_key       (in_client_key),
    .in_key_present      (in_key_present),
    .in_time_now         (in_time_now),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_blocked_seconds (out_blocked_seconds),
    .out_dropped         (out_dropped),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Times are compared through their exact signed difference, never modulo 2^32.
  function automatic logic window_expired(int slot, logic [fal_pkg::TIME_W-1:0] now);
    longint elapsed;
    elapsed = longint'({32'd0, now}) - longint'({32'd0, rec_start[slot]});
    return elapsed >= longint'({40'd0, lim_window});
  endfunction

  function automatic int count_records();
    int n;
    n = 0;
    for (int i = 0; i < DEPTH; i++) if (rec_valid[i]) n++;
    return n;
  endfunction

  function automatic void restart_record(int slot, logic [fal_pkg::KEY_W-1:0] key,
                                         logic [fal_pkg::TIME_W-1:0] now);
    rec_valid[slot] = 1'b1;
    rec_key[slot]   = key;
    rec_start[slot] = now;
    rec_count[slot] = '0;
    rec_until[slot] = '0;
  endfunction

  function automatic reply_t compute_reply(logic [1:0] op, logic [fal_pkg::KEY_W-1:0] key,
                                           logic present,
                                           logic [fal_pkg::TIME_W-1:0] now);
    reply_t r;
    int     slot;
    logic   blocked;
    logic   counting;
    longint left;
    r.secs    = '0;
    r.dropped = 1'b0;
    if (!present) return r;
    slot = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot < 0 && rec_valid[i] && rec_key[i] == key) slot = i;
    end
    case (op)
      fal_pkg::OP_FAIL: begin
        if (slot < 0) begin
          // A full table first loses the records that are neither blocked nor counting.
          if (count_records() >= DEPTH) begin
            for (int i = 0; i < DEPTH; i++) begin
              blocked  = rec_until[i] != '0 && rec_until[i] > now;
              counting = rec_until[i] == '0 && !window_expired(i, now);
              if (rec_valid[i] && !blocked && !counting) rec_valid[i] = 1'b0;
            end
          end
          if (count_records() >= DEPTH) begin
            r.dropped = 1'b1;
          end else begin
            slot = 0;
            while (rec_valid[slot]) slot++;
            restart_record(slot, key, now);
          end
        end else if (rec_until[slot] != '0 || window_expired(slot, now)) begin
          restart_record(slot, key, now);
        end
        if (!r.dropped) begin
          if (rec_count[slot] < fal_pkg::COUNT_MAX) rec_count[slot]++;
          if (rec_count[slot] >= lim_max_fails) begin
            rec_until[slot] = now + {8'd0, lim_block};
            rec_count[slot] = '0;
            r.secs          = lim_block;
          end
        end
      end
      fal_pkg::OP_QUERY: begin
        if (slot >= 0 && rec_until[slot] != '0) begin
          left = longint'({32'd0, rec_until[slot]}) - longint'({32'd0, now});
          if (left <= 0) rec_valid[slot] = 1'b0;
          else if (left > longint'(fal_pkg::SECONDS_MAX)) r.secs = fal_pkg::SECONDS_MAX;
          else r.secs = left[fal_pkg::SECS_W-1:0];
        end
      end
      fal_pkg::OP_FORGET: begin
        if (slot >= 0) rec_valid[slot] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // The sender runs in bursts; valid only drops when a gap is taken.
  task automatic send_word(input logic [1:0] op, input logic [fal_pkg::KEY_W-1:0] key,
                           input logic present, input logic [fal_pkg::TIME_W-1:0] now);
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 8))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_client_key  <= key;
    in_key_present <= present;
    in_time_now    <= now;
    do @(posedge clk); while (in_stall !== 1'b0);
    replies_due.push_back(compute_reply(op, key, present, now));
    burst_left--;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Writes all three limits, then a word to the unused index that must be ignored.
  task automatic write_limits(input logic [fal_pkg::CNT_W-1:0] max_fails,
                              input logic [fal_pkg::CFG_W-1:0] window,
                              input logic [fal_pkg::CFG_W-1:0] block_len);
    logic [fal_pkg::CFG_W-fal_pkg::CNT_W-1:0] junk;
    junk = (fal_pkg::CFG_W - fal_pkg::CNT_W)'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= fal_pkg::CFG_MAX_FAILS;
    cfg_wdata <= {junk, max_fails};
    @(posedge clk);
    lim_max_fails = max_fails;
    cfg_index <= fal_pkg::CFG_WINDOW;
    cfg_wdata <= window;
    @(posedge clk);
    lim_window = window;
    cfg_index <= fal_pkg::CFG_BLOCK;
    cfg_wdata <= block_len;
    @(posedge clk);
    lim_block = block_len;
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= fal_pkg::CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_traffic(int words, int pool, int fail_pct, int step_max, int jump_max);
    logic [fal_pkg::KEY_W-1:0]  pool_keys[128];
    logic [fal_pkg::TIME_W-1:0] now;
    logic [1:0]                 op;
    logic [fal_pkg::KEY_W-1:0]  key;
    logic                       present;
    int                         pick;
    now = $urandom;
    for (int k = 0; k < pool; k++) pool_keys[k] = {$urandom, $urandom};
    repeat (words) begin
      pick = $urandom_range(0, 99);
      if (pick < fail_pct) op = fal_pkg::OP_FAIL;
      else if (pick < fail_pct + (100 - fail_pct) * 2 / 3) op = fal_pkg::OP_QUERY;
      else if (pick < 97) op = fal_pkg::OP_FORGET;
      else op = OP_UNUSED;
      present = ($urandom_range(0, 24) != 0);
      key = ($urandom_range(0, 9) != 0) ? pool_keys[$urandom_range(0, pool - 1)]
                                        : {$urandom, $urandom};
      pick = $urandom_range(0, 49);
      if (pick == 0) now = $urandom;
      else if (pick < 3) now = now + $urandom_range(0, jump_max);
      else if (pick == 3) now = now - $urandom_range(0, step_max);
      else now = now + $urandom_range(0, step_max);
      send_word(op, key, present, now);
    end
  endtask

  task automatic test_basic_ops();
    logic [fal_pkg::KEY_W-1:0] key_ones;
    key_ones = '1;
    send_word(fal_pkg::OP_FAIL, key_ones, 1'b0, 32'd100);
    send_word(OP_UNUSED, key_ones, 1'b1, 32'd100);
    send_word(fal_pkg::OP_QUERY, key_ones, 1'b1, 32'd100);
    send_word(fal_pkg::OP_FORGET, key_ones, 1'b1, 32'd100);
    for (int n = 0; n < 5; n++) send_word(fal_pkg::OP_FAIL, key_ones, 1'b1, 32'd100 + n);
    send_word(fal_pkg::OP_QUERY, key_ones, 1'b1, 32'd500);
    // Time running backwards during a block.
    send_word(fal_pkg::OP_QUERY, key_ones, 1'b1, 32'd0);
    send_word(fal_pkg::OP_FAIL, '0, 1'b1, 32'hFFFF_FFFF);
    send_word(fal_pkg::OP_FAIL, key_ones, 1'b1, 32'd2000);
    send_word(fal_pkg::OP_FORGET, key_ones, 1'b1, 32'd2000);
    send_word(fal_pkg::OP_QUERY, key_ones, 1'b1, 32'd2000);
    wait_idle();
  endtask

  task automatic test_limit_extremes();
    logic [fal_pkg::KEY_W-1:0] key_a;
    logic [fal_pkg::KEY_W-1:0] key_b;
    key_a = 64'h0123_4567_89AB_CDEF;
    key_b = 64'hFEDC_BA98_7654_3210;
    write_limits(8'd1, '0, fal_pkg::SECONDS_MAX);
    // The block end wraps to exactly zero, which reads as not blocked.
    send_word(fal_pkg::OP_FAIL, key_a, 1'b1, 32'hFF00_0001);
    send_word(fal_pkg::OP_QUERY, key_a, 1'b1, 32'hFF00_0001);
    send_word(fal_pkg::OP_FAIL, key_b, 1'b1, 32'h8000_0000);
    send_word(fal_pkg::OP_QUERY, key_b, 1'b1, 32'h0000_0000);
    send_word(fal_pkg::OP_QUERY, key_b, 1'b1, 32'hFFFF_FFFF);
    send_word(fal_pkg::OP_QUERY, key_b, 1'b1, 32'd5);
    wait_idle();
    write_limits(8'd0, '1, '0);
    send_word(fal_pkg::OP_FAIL, key_a, 1'b1, 32'd5);
    send_word(fal_pkg::OP_QUERY, key_a, 1'b1, 32'd5);
    wait_idle();
    write_limits(8'hFF, '1, 24'd1);
    send_word(fal_pkg::OP_FAIL, key_b, 1'b1, 32'd7);
    send_word(fal_pkg::OP_FAIL, key_b, 1'b1, 32'd7);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    write_limits(fal_pkg::MAX_FAILS_RST, fal_pkg::WINDOW_RST, fal_pkg::BLOCK_RST);
    run_traffic(80, 8, 60, 60, 2000);
    wait_idle();
    write_limits(8'd1, '0, fal_pkg::SECONDS_MAX);
    run_traffic(50, 6, 60, 10, 100000);
    wait_idle();
    write_limits(8'd0, '1, '0);
    run_traffic(40, 6, 60, 10, 1000);
    wait_idle();
    write_limits(8'hFF, '1, fal_pkg::CFG_W'($urandom));
    run_traffic(30, 3, 70, 5, 1000);
    wait_idle();
    // Many clients and a long window fill the table, so drops and sweeps happen.
    write_limits(8'd200, 24'd100000, 24'd1000);
    run_traffic(160, 96, 85, 3, 300000);
    wait_idle();
    write_limits(fal_pkg::CNT_W'($urandom_range(1, 8)),
                 fal_pkg::CFG_W'($urandom_range(0, 2000)),
                 fal_pkg::CFG_W'($urandom_range(0, 5000)));
    run_traffic(90, 12, 60, 200, 20000);
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) rec_valid[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_limit_extremes();
    test_random_traffic();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_run  = $urandom_range(16, 300);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_stall <= ($urandom_range(0, 15) != 0);
      default:     out_stall <= stall_run[2];
    endcase
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("ERROR: result %0d %s: got %0h, expected %0h", results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (replies_due.size() == 0) begin
        report_mismatch("word with nothing expected", out_blocked_seconds, 0);
      end else begin
        reply_head = replies_due.pop_front();
        if (out_blocked_seconds !== reply_head.secs)
          report_mismatch("blocked_seconds", out_blocked_seconds, reply_head.secs);
        if (out_dropped !== reply_head.dropped)
          report_mismatch("dropped", out_dropped, reply_head.dropped);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
